FILE: hw/rtl/bsb_pkg.sv
// Shared types and constants for the bounding-sphere block.
// Depends on nothing; every other file imports it.
package bsb_pkg;

	// Three axes, index 0 is x, 1 is y, 2 is z
	localparam int AXES = 3;

	// Job queue depth between front and back; keep it a power of two
	localparam int Q_DEPTH = 2;

	typedef logic signed [31:0] coord_t;
	typedef logic [31:0] ucoord_t;

	// Tracker start values
	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	// One finished vertex set, handed from front to back
	typedef struct packed {
		logic                   seen;
		logic [AXES-1:0][31:0]  lo;
		logic [AXES-1:0][31:0]  hi;
	} job_t;

	// Back-end sequencer states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CTR  = 8'b0000_0010,
		ST_DIF  = 8'b0000_0100,
		ST_SQR  = 8'b0000_1000,
		ST_SUMA = 8'b0001_0000,
		ST_SUMB = 8'b0010_0000,
		ST_ROOT = 8'b0100_0000,
		ST_HOLD = 8'b1000_0000
	} back_state_t;

endpackage

FILE: hw/rtl/bounding_sphere_from_box.sv
// Bounding sphere from box: vertex stream in, one sphere per set out.
// Front end takes one vertex per cycle while full is low; the min/max
// compare is combinational. The back end works on one set at a time and
// finishes it, through its 32-step square root, before it takes the next;
// an empty set skips the root. Two sets can wait in the queue between ends.
// Asynchronous active-low reset clears trackers, queue and result slot.
module bounding_sphere_from_box #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bsb_pkg::coord_t  pos_x,
	input  bsb_pkg::coord_t  pos_y,
	input  bsb_pkg::coord_t  pos_z,
	input  logic             has_vertex,
	input  logic             last,
	input  logic             push,
	output logic             full,
	output bsb_pkg::coord_t  center_x,
	output bsb_pkg::coord_t  center_y,
	output bsb_pkg::coord_t  center_z,
	output bsb_pkg::ucoord_t radius,
	output logic             empty,
	input  logic             pop
);
	import bsb_pkg::*;

	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_empty;
	job_t job_in;
	job_t job_out;

	// Accept and track vertices
	bsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.has_vertex (has_vertex),
		.last       (last),
		.push       (push),
		.full       (full),
		.job_push   (job_push),
		.job_data   (job_in),
		.job_full   (job_full)
	);

	// Decouple the ends
	bsb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	// Compute the sphere
	bsb_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (job_empty),
		.q_data   (job_out),
		.q_pop    (job_pop),
		.empty    (empty),
		.pop      (pop),
		.center_x (center_x),
		.center_y (center_y),
		.center_z (center_z),
		.radius   (radius)
	);

endmodule

FILE: hw/rtl/bsb_front.sv
// Front end: accepts vertex transactions and tracks per-axis min and max.
// On the last item of a set it pushes a job to the queue. Uses bsb_pkg.
module bsb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  bsb_pkg::coord_t pos_x,
	input  bsb_pkg::coord_t pos_y,
	input  bsb_pkg::coord_t pos_z,
	input  logic            has_vertex,
	input  logic            last,
	input  logic            push,
	output logic            full,
	output logic            job_push,
	output bsb_pkg::job_t   job_data,
	input  logic            job_full
);
	import bsb_pkg::*;

	logic [AXES-1:0][31:0] lo_q;
	logic [AXES-1:0][31:0] hi_q;
	logic                  seen_q;
	logic [AXES-1:0][31:0] pos;
	logic [AXES-1:0][31:0] lo_nx;
	logic [AXES-1:0][31:0] hi_nx;
	logic                  accept;

	assign pos = {pos_z, pos_y, pos_x};

	// Fold the incoming vertex into the trackers
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			lo_nx[a] = (has_vertex && ($signed(pos[a]) < $signed(lo_q[a]))) ? pos[a] : lo_q[a];
			hi_nx[a] = (has_vertex && ($signed(pos[a]) > $signed(hi_q[a]))) ? pos[a] : hi_q[a];
		end
	end

	// Stall the input only when the job queue has no room
	assign full     = job_full;
	assign accept   = push & ~job_full;
	assign job_push = accept & last;

	always_comb begin
		job_data.seen = seen_q | has_vertex;
		job_data.lo   = lo_nx;
		job_data.hi   = hi_nx;
	end

	// Advance trackers; return them to start values after a set closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= {AXES{COORD_MAX}};
			hi_q   <= {AXES{COORD_MIN}};
			seen_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				lo_q   <= {AXES{COORD_MAX}};
				hi_q   <= {AXES{COORD_MIN}};
				seen_q <= 1'b0;
			end else begin
				lo_q   <= lo_nx;
				hi_q   <= hi_nx;
				seen_q <= seen_q | has_vertex;
			end
		end
	end

endmodule

FILE: hw/rtl/bsb_queue.sv
// Short job queue between front and back ends, register based.
// Depth from bsb_pkg::Q_DEPTH; uses bsb_pkg::job_t.
module bsb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bsb_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output bsb_pkg::job_t dout,
	output logic          empty
);
	import bsb_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	job_t            mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	// Store the job at the write pointer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/bsb_back.sv
// Back end: center, squared distances and a bit-serial square root per job.
// Holds one finished result for the output side. Uses bsb_pkg.
module bsb_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  bsb_pkg::job_t   q_data,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output bsb_pkg::coord_t center_x,
	output bsb_pkg::coord_t center_y,
	output bsb_pkg::coord_t center_z,
	output bsb_pkg::ucoord_t radius
);
	import bsb_pkg::*;

	localparam logic [31:0] RADIUS_ONE = 32'(64'd1 << FRAC_BITS);

	back_state_t           state_q;
	back_state_t           state_nx;
	logic [4:0]            cnt_q;
	logic                  res_valid_q;
	logic                  res_load;

	logic [AXES-1:0][31:0] lo_q;
	logic [AXES-1:0][31:0] hi_q;
	logic [AXES-1:0][31:0] c_q;
	logic [AXES-1:0][31:0] d_q;
	logic [AXES-1:0][63:0] sq_q;
	logic [63:0]           acc_q;
	logic [63:0]           n_q;
	logic [32:0]           rem_q;
	logic [31:0]           root_q;
	logic [31:0]           res_cx_q;
	logic [31:0]           res_cy_q;
	logic [31:0]           res_cz_q;
	logic [31:0]           res_rad_q;

	logic [AXES-1:0][32:0] sum33;
	logic [AXES-1:0][63:0] sq_nx;
	logic [34:0]           rem_sh;
	logic [34:0]           trial;
	logic [34:0]           rem_nx;
	logic                  ge;

	// Center sum at 33 bits, squares, and one root digit
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum33[a] = {lo_q[a][31], lo_q[a]} + {hi_q[a][31], hi_q[a]};
			sq_nx[a] = 64'(d_q[a]) * 64'(d_q[a]);
		end
		rem_sh = {rem_q, n_q[63:62]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign res_load = (state_q == ST_HOLD) && (!res_valid_q || pop);

	// Sequencer
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_nx = q_data.seen ? ST_CTR : ST_HOLD;
				end
			end
			ST_CTR:  state_nx = ST_DIF;
			ST_DIF:  state_nx = ST_SQR;
			ST_SQR:  state_nx = ST_SUMA;
			ST_SUMA: state_nx = ST_SUMB;
			ST_SUMB: state_nx = ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == '1) begin
					state_nx = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (res_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lo_q   <= q_data.lo;
				hi_q   <= q_data.hi;
				c_q    <= '0;
				root_q <= RADIUS_ONE;
			end
			ST_CTR: begin
				for (int a = 0; a < AXES; a++) begin
					c_q[a] <= sum33[a][32:1];
				end
			end
			ST_DIF: begin
				for (int a = 0; a < AXES; a++) begin
					d_q[a] <= hi_q[a] - c_q[a];
				end
			end
			ST_SQR:  sq_q  <= sq_nx;
			ST_SUMA: acc_q <= sq_q[0] + sq_q[1];
			ST_SUMB: begin
				n_q    <= acc_q + sq_q[2];
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ST_ROOT: begin
				n_q    <= {n_q[61:0], 2'b00};
				rem_q  <= rem_nx[32:0];
				root_q <= {root_q[30:0], ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_HOLD: begin
				if (res_load) begin
					res_cx_q  <= c_q[0];
					res_cy_q  <= c_q[1];
					res_cz_q  <= c_q[2];
					res_rad_q <= root_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty    = ~res_valid_q;
	assign center_x = res_cx_q;
	assign center_y = res_cy_q;
	assign center_z = res_cz_q;
	assign radius   = res_rad_q;

endmodule

FILE: hw/rtl/bsb_checker.sv
// Port-level checks for bounding_sphere_from_box, attached by bind.
// Depends on bsb_pkg for port types.
module bsb_checker (
	input logic             clk,
	input logic             arst_n,
	input bsb_pkg::coord_t  pos_x,
	input bsb_pkg::coord_t  pos_y,
	input bsb_pkg::coord_t  pos_z,
	input logic             has_vertex,
	input logic             last,
	input logic             push,
	input logic             full,
	input bsb_pkg::coord_t  center_x,
	input bsb_pkg::coord_t  center_y,
	input bsb_pkg::coord_t  center_z,
	input bsb_pkg::ucoord_t radius,
	input logic             empty,
	input logic             pop
);
	import bsb_pkg::*;

	// Hold a waiting result until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(center_x) && $stable(center_y)
			&& $stable(center_z) && $stable(radius)))
		else $error("result changed or vanished while waiting");

	// A result leaves only through a pop transaction
	a_res_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result dropped without pop");

	// The queue fills only when a set is closed by a last item
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && last))
		else $error("input stalled without a closed set");

	// An accepted input transaction carries known values
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> !$isunknown({pos_x, pos_y, pos_z, has_vertex, last}))
		else $error("unknown value on an accepted input transaction");

endmodule

bind bounding_sphere_from_box bsb_checker u_bsb_checker (.*);
